### sv/mip_pkg.sv
// ----------------------------------------------------------------------------
// mip_pkg: shared definitions for the modular inverse block
// Holds the prime modulus, the controller state type, the command and status
// groups between controller and datapath, and the halving helper.
// ----------------------------------------------------------------------------
`default_nettype none

package mip_pkg;

  // Operand width and the fixed prime modulus.
  localparam int unsigned DataW = 30;
  localparam logic [DataW-1:0] Modulus = 30'd998244353;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic capture;
  } mip_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic finished;
  } mip_status_t;

  // Returns (a - b) / 2 modulo the prime, for a and b below the modulus.
  // The difference is first brought into range, then made even by adding
  // the modulus when odd, so the halving is exact.
  function automatic logic [DataW-1:0] sub_half_mod(input logic [DataW-1:0] a,
                                                    input logic [DataW-1:0] b);
    logic [DataW+1:0] diff;
    logic [DataW+1:0] corr;
    logic [DataW+1:0] sum;
    logic             neg;
    logic             odd;
    diff = {2'b00, a} - {2'b00, b};
    neg  = diff[DataW+1];
    // Adding the odd modulus flips the parity of the difference.
    odd  = diff[0] ^ neg;
    if (neg && odd) begin
      corr = {2'b00, Modulus} + {2'b00, Modulus};
    end else if (neg || odd) begin
      corr = {2'b00, Modulus};
    end else begin
      corr = '0;
    end
    sum = diff + corr;
    return sum[DataW:1];
  endfunction

endpackage

`default_nettype wire

### sv/mip_datapath.sv
// ----------------------------------------------------------------------------
// mip_datapath: binary extended GCD datapath
// Keeps the two remainders and their coefficients, performs one combined
// subtract-and-halve step per command and holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mip_datapath (
  input  wire logic                         clk,
  input  wire mip_pkg::mip_cmd_t            cmd,
  input  wire logic [mip_pkg::DataW-1:0]    value,
  output      mip_pkg::mip_status_t         status,
  output      logic [mip_pkg::DataW-1:0]    inverse
);

  // Remainders u, v and coefficients x1, x2 with x1*a = u and x2*a = v.
  logic [mip_pkg::DataW-1:0] u;
  logic [mip_pkg::DataW-1:0] v;
  logic [mip_pkg::DataW-1:0] x1;
  logic [mip_pkg::DataW-1:0] x2;

  logic [mip_pkg::DataW-1:0] reduced;
  logic [mip_pkg::DataW-1:0] r_big;
  logic [mip_pkg::DataW-1:0] r_small;
  logic [mip_pkg::DataW-1:0] c_big;
  logic [mip_pkg::DataW-1:0] c_small;
  logic [mip_pkg::DataW-1:0] r_new;
  logic [mip_pkg::DataW-1:0] c_new;
  logic                      to_u;
  logic [mip_pkg::DataW-1:0] result;

  // Input reduction by one conditional subtraction of the modulus.
  assign reduced = (value >= mip_pkg::Modulus) ? (value - mip_pkg::Modulus) : value;

  // Operand selection: halve an even remainder, otherwise subtract the
  // smaller odd remainder from the larger one and halve the difference.
  always_comb begin
    to_u    = 1'b1;
    r_big   = u;
    r_small = '0;
    c_big   = x1;
    c_small = '0;
    if (!u[0]) begin
      to_u = 1'b1;
    end else if (!v[0]) begin
      to_u    = 1'b0;
      r_big   = v;
      c_big   = x2;
    end else if (u >= v) begin
      to_u    = 1'b1;
      r_small = v;
      c_small = x2;
    end else begin
      to_u    = 1'b0;
      r_big   = v;
      r_small = u;
      c_big   = x2;
      c_small = x1;
    end
  end

  assign r_new = (r_big - r_small) >> 1;
  assign c_new = mip_pkg::sub_half_mod(c_big, c_small);

  // The loop ends when either remainder reaches one, or at once for zero.
  assign status.finished = (u == mip_pkg::DataW'(1)) || (v == mip_pkg::DataW'(1)) ||
                           (u == '0);

  // The coefficient paired with the remainder that reached one.
  always_comb begin
    if (u == mip_pkg::DataW'(1)) begin
      result = x1;
    end else if (v == mip_pkg::DataW'(1)) begin
      result = x2;
    end else begin
      result = '0;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      u  <= reduced;
      v  <= mip_pkg::Modulus;
      x1 <= mip_pkg::DataW'(1);
      x2 <= '0;
    end else if (cmd.step) begin
      if (to_u) begin
        u  <= r_new;
        x1 <= c_new;
      end else begin
        v  <= r_new;
        x2 <= c_new;
      end
    end
  end

  // Result register, stable while the next item runs.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      inverse <= result;
    end
  end

endmodule

`default_nettype wire

### sv/mip_ctrl.sv
// ----------------------------------------------------------------------------
// mip_ctrl: controller for the modular inverse block
// Accepts an item, steps the datapath until it reports completion, then
// captures the result and raises the strobe for one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mip_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire mip_pkg::mip_status_t status,
  output      mip_pkg::mip_cmd_t    cmd,
  output      logic                 busy,
  output      logic                 done
);

  mip_pkg::state_t state;
  mip_pkg::state_t state_next;
  logic            done_next;

  // State and strobe registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mip_pkg::ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  // Next state and datapath commands.
  always_comb begin
    state_next  = state;
    done_next   = 1'b0;
    cmd.load    = 1'b0;
    cmd.step    = 1'b0;
    cmd.capture = 1'b0;
    unique case (state)
      mip_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = mip_pkg::ST_RUN;
        end
      end
      mip_pkg::ST_RUN: begin
        if (status.finished) begin
          cmd.capture = 1'b1;
          done_next   = 1'b1;
          state_next  = mip_pkg::ST_IDLE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      default: begin
        state_next = mip_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state != mip_pkg::ST_IDLE);

endmodule

`default_nettype wire

### sv/modular_inverse_prime.sv
// ----------------------------------------------------------------------------
// modular_inverse_prime: inverse modulo the prime 998244353
// Binary extended GCD with a controller and a one-step-per-cycle datapath.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; value is first reduced
// by one conditional subtraction of the modulus. The datapath then runs one
// combined subtract-and-halve step of the binary extended GCD per cycle; each
// step at least halves the product of the two remainders, so the loop ends, and
// a finishing cycle follows the last step. done pulses for one cycle with inverse
// valid in the cycle after that finishing cycle. busy is already low in the
// strobe cycle, so the next item may be started then. A zero input gives 0. The
// result must be taken in the strobe cycle; it is held until the next result.
// ----------------------------------------------------------------------------
`default_nettype none

module modular_inverse_prime (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  output      logic                      busy,
  input  wire logic [mip_pkg::DataW-1:0] value,
  output      logic                      done,
  output      logic [mip_pkg::DataW-1:0] inverse
);

  mip_pkg::mip_cmd_t    cmd;
  mip_pkg::mip_status_t status;

  // Controller.
  mip_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // Datapath.
  mip_datapath u_datapath (
    .clk     (clk),
    .cmd     (cmd),
    .value   (value),
    .status  (status),
    .inverse (inverse)
  );

endmodule

`default_nettype wire

### sv/mip_checker.sv
// ----------------------------------------------------------------------------
// mip_checker: port-level checks for the modular inverse block
// Watches the handshake and strobe over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mip_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done
);

  // An accepted item makes the block busy in the next cycle.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // The block leaves busy only by delivering a result.
  assert property (@(posedge clk) disable iff (rst) $fell(busy) |-> done)
    else $error("busy fell without a result");

  // A result always follows a busy cycle, and is never shown while busy.
  assert property (@(posedge clk) disable iff (rst) done |-> (!busy && $past(busy)))
    else $error("result strobe outside the end of an item");

  // One item gives exactly one strobe cycle.
  assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe lasted more than one cycle");

endmodule

bind modular_inverse_prime mip_checker u_mip_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

`default_nettype wire
